// ===== design/lphs_pkg.sv =====
// Shared types, widths and codes of the linear-probing hash set.
`timescale 1ns / 1ps

package lphs_pkg;

	// Table geometry: the slot count is a power of two, so the home slot is a part-select.
	localparam int SLOT_W     = 6;
	localparam int TABLE_SIZE = 2 ** SLOT_W;
	localparam int OCC_W      = SLOT_W + 1;

	// Port field widths.
	localparam int REQ_W  = 2;
	localparam int KEY_W  = 44;
	localparam int HASH_W = 31;
	localparam int STAT_W = 3;
	localparam int POS_W  = 6;
	localparam int LIVE_W = 7;
	localparam int MARK_W = 2;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;
	localparam logic [STAT_W-1:0] STAT_DELETED   = 3'd5;
	localparam logic [STAT_W-1:0] STAT_COUNT     = 3'd6;

	// Slot marks.
	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

	// One table entry as it is kept in memory.
	typedef struct packed {
		logic [MARK_W-1:0] mark;
		logic [KEY_W-1:0]  key;
	} slot_entry_t;

	// Access request from the probe controller to the slot store.
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		slot_entry_t       wr_data;
	} store_req_t;

endpackage

// ===== design/lphs_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module lphs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/lphs_store.sv =====
// Slot store: entry memory plus per-slot valid bits so the table starts empty.
`timescale 1ns / 1ps

module lphs_store import lphs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  store_req_t  req,
	output slot_entry_t rd_slot
);

	localparam int ENTRY_W = $bits(slot_entry_t);

	logic [ENTRY_W-1:0]   ram_rd_data;
	logic [TABLE_SIZE-1:0] valid_q;
	logic                 vld_s1;
	slot_entry_t          ram_entry;

	lphs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk    (clk),
		.rd_en  (req.rd_en),
		.rd_addr(req.rd_addr),
		.rd_data(ram_rd_data),
		.wr_en  (req.wr_en),
		.wr_addr(req.wr_addr),
		.wr_data(req.wr_data)
	);

	// A slot becomes valid at its first write; until then it reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= valid_q[req.rd_addr];
			end
		end
	end

	// Mask the mark of a never-written slot to empty.
	always_comb begin
		ram_entry    = slot_entry_t'(ram_rd_data);
		rd_slot.key  = ram_entry.key;
		rd_slot.mark = vld_s1 ? ram_entry.mark : MARK_EMPTY;
	end

endmodule

// ===== design/linear_probe_hash_set_core.sv =====
// Top level of the linear-probing hash set: probe controller, live counter and result register.
//
// The block keeps a set of 44-bit keys in a 64-slot open-addressed table held in one
// synchronous memory; the caller supplies the hash, and the home slot is its low six bits.
// Insert, lookup and delete walk the probe path one slot per memory read: the request is
// accepted and its home read issued, each probed slot is checked in turn (1 to 64 slots
// in all), then the slot is written back when needed and the result register is loaded;
// that last step waits while the output register holds a result not yet taken. A count
// request skips the probe. One request is in work at a time; the next is accepted as soon
// as the previous result sits in the output register, even while it waits to be taken.
// The table is empty right after reset: per-slot valid bits make unwritten slots read as
// empty, so there is no clearing pass.
`timescale 1ns / 1ps

module linear_probe_hash_set_core import lphs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [KEY_W-1:0]  key,
	input  logic [HASH_W-1:0] hash_code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [POS_W-1:0]  position,
	output logic [LIVE_W-1:0] live_count,
	output logic              is_empty
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_DONE  = 2'd2;

	localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(TABLE_SIZE - 1);
	localparam logic [OCC_W-1:0]  OCC_MAX   = OCC_W'(TABLE_SIZE);

	logic [1:0]        state_q;
	logic [REQ_W-1:0]  req_q;
	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] addr_q;
	logic [SLOT_W-1:0] step_q;
	logic [SLOT_W-1:0] free_q;
	logic              have_free_q;
	logic [STAT_W-1:0] stat_q;
	logic [SLOT_W-1:0] pos_q;
	logic [OCC_W-1:0]  occ_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [POS_W-1:0]  position_q;
	logic [LIVE_W-1:0] live_count_q;
	logic              is_empty_q;

	store_req_t        st_req;
	slot_entry_t       rd_slot;

	logic              in_fire;
	logic              out_load;
	logic              slot_hit;
	logic              slot_hole;
	logic              slot_free;
	logic              probe_last;
	logic              probe_end;
	logic [STAT_W-1:0] end_stat;
	logic [SLOT_W-1:0] end_pos;
	logic [OCC_W-1:0]  occ_next;

	lphs_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.rd_slot(rd_slot)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Classify the slot whose data arrived this cycle and decide whether the probe ends.
	always_comb begin
		slot_hit   = (rd_slot.mark == MARK_LIVE) && (rd_slot.key == key_q);
		slot_hole  = (rd_slot.mark == MARK_EMPTY);
		slot_free  = (rd_slot.mark != MARK_LIVE);
		probe_last = (step_q == LAST_STEP);
		probe_end  = slot_hit || slot_hole || probe_last;
		end_stat   = STAT_NOT_FOUND;
		end_pos    = '0;
		if (slot_hit) begin
			end_pos = addr_q;
			case (req_q)
				REQ_INSERT: end_stat = STAT_DUPLICATE;
				REQ_LOOKUP: end_stat = STAT_FOUND;
				REQ_DELETE: end_stat = STAT_DELETED;
				default:    end_stat = STAT_COUNT;
			endcase
		end else if (req_q == REQ_INSERT) begin
			// First empty or deleted slot on the path, or full after a whole wrap.
			if (have_free_q) begin
				end_stat = STAT_INSERTED;
				end_pos  = free_q;
			end else if (slot_free) begin
				end_stat = STAT_INSERTED;
				end_pos  = addr_q;
			end else begin
				end_stat = STAT_FULL;
			end
		end
	end

	// Memory accesses: home read at acceptance, next slot while probing, write-back at the end.
	always_comb begin
		st_req              = '0;
		st_req.wr_addr      = pos_q;
		st_req.wr_data.key  = key_q;
		st_req.wr_data.mark = (stat_q == STAT_INSERTED) ? MARK_LIVE : MARK_GONE;
		st_req.wr_en        = out_load &&
		                      ((stat_q == STAT_INSERTED) || (stat_q == STAT_DELETED));
		if (state_q == S_IDLE) begin
			st_req.rd_en   = in_fire && (req_type != REQ_COUNT);
			st_req.rd_addr = hash_code[SLOT_W-1:0];
		end else begin
			st_req.rd_en   = (state_q == S_CHECK) && !probe_end;
			st_req.rd_addr = addr_q + SLOT_W'(1);
		end
	end

	// Live entry count after the current request.
	always_comb begin
		occ_next = occ_q;
		if (stat_q == STAT_INSERTED) begin
			occ_next = occ_q + OCC_W'(1);
		end else if ((stat_q == STAT_DELETED) && (occ_q != '0)) begin
			occ_next = occ_q - OCC_W'(1);
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			have_free_q <= 1'b0;
			occ_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						have_free_q <= 1'b0;
						state_q     <= (req_type == REQ_COUNT) ? S_DONE : S_CHECK;
					end
				end
				S_CHECK: begin
					if (probe_end) begin
						state_q <= S_DONE;
					end else if (!have_free_q && slot_free) begin
						have_free_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (out_load) begin
						occ_q   <= occ_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request payload and probe position.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q  <= req_type;
			key_q  <= key;
			addr_q <= hash_code[SLOT_W-1:0];
			step_q <= '0;
			stat_q <= STAT_COUNT;
			pos_q  <= '0;
		end else if (state_q == S_CHECK) begin
			if (probe_end) begin
				stat_q <= end_stat;
				pos_q  <= end_pos;
			end else begin
				addr_q <= addr_q + SLOT_W'(1);
				step_q <= step_q + SLOT_W'(1);
				if (!have_free_q && slot_free) begin
					free_q <= addr_q;
				end
			end
		end
	end

	// Output register: holds a finished transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= stat_q;
			position_q   <= POS_W'(pos_q);
			live_count_q <= LIVE_W'(occ_next);
			is_empty_q   <= (occ_next == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign position   = position_q;
	assign live_count = live_count_q;
	assign is_empty   = is_empty_q;

	// The live counter never exceeds the table size.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_MAX)
		else $error("live counter exceeds table size");

	// The table is written only when a result is loaded.
	a_write_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_req.wr_en |-> (state_q == S_DONE) && out_load)
		else $error("table write outside result load");

	// No read is issued while a result waits to be loaded.
	a_no_read_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !st_req.rd_en)
		else $error("memory read during write-back");

	// A new result appears only after the finishing cycle.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside finishing cycle");

	// A probe never runs past one full wrap of the table.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) && probe_last |=> (state_q == S_DONE))
		else $error("probe ran past a full wrap");

endmodule
